// File: sv/stfd_pkg.sv
// Shared types and codes for the sorted table block.
`default_nettype none
package stfd_pkg;

   localparam int KEY_W = 32;
   localparam int ACT_W = 2;
   localparam int STAT_W = 2;
   localparam int POS_W = 6;
   localparam int CNT_W = 7;
   localparam int RSP_W = 16;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_FIND   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

   localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

   // compare results latched in each cell
   typedef struct packed {
      logic ins;   // empty, or entry greater than key
      logic ge;    // occupied and entry not below key
      logic eq;    // occupied and entry equals key
   } stfd_flags_type;

   typedef struct packed {
      logic compare;
      logic shift_ins;
      logic shift_del;
   } stfd_ctl_type;

endpackage
`default_nettype wire

// File: sv/stfd_cell.sv
// One table slot: compares against the key and shifts with its neighbors.
`default_nettype none
module stfd_cell
   import stfd_pkg::*;
#(
   parameter int IDX = 0,
   parameter int CW  = 7
) (
   input  wire logic                   clock,
   input  wire stfd_ctl_type           ctl,
   input  wire logic signed [KEY_W-1:0] key,
   input  wire logic [CW-1:0]          count,
   input  wire logic signed [KEY_W-1:0] left_entry,
   input  wire stfd_flags_type         left_flags,
   input  wire logic signed [KEY_W-1:0] right_entry,
   output logic signed [KEY_W-1:0]     entry,
   output stfd_flags_type              flags
);

   logic signed [KEY_W-1:0] entry_ff, entry_in;
   stfd_flags_type flags_ff, flags_in;
   logic occ;

   assign occ = (CW'(IDX) < count);

   always_comb begin
      flags_in = flags_ff;
      if (ctl.compare) begin
         flags_in.ins = !occ || (entry_ff > key);
         flags_in.ge  = occ && (entry_ff >= key);
         flags_in.eq  = occ && (entry_ff == key);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      priority if (ctl.shift_ins) begin
         if (left_flags.ins) begin
            entry_in = left_entry;
         end else if (flags_ff.ins) begin
            entry_in = key;
         end
      end else if (ctl.shift_del && flags_ff.ge) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flags_ff <= flags_in;
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule
`default_nettype wire

// File: sv/sorted_table_insert_find_delete_top.sv
// Top level: request/response control, position encode and the row of cells.
// A request accepted in S_IDLE passes through S_CMP and S_APPLY; its response beat is registered on commit.
// Requests do not overlap: the compare cycle and the shift cycle of the cell row
// run one after the other and the row holds one request at a time.
// A waiting response beat stalls only the shift cycle of the next request.
// Reset clears the count and the control; table contents are left as they are.
`default_nettype none
module sorted_table_insert_find_delete_top
   import stfd_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // value[31:0]
   input  wire logic [1:0]  req_tuser,   // action[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // status[1:0], position[7:2], entry_count[14:8], 0
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [ACT_W-1:0] action_ff, action_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [KEY_W-1:0] entries [TABLE_DEPTH];
   stfd_flags_type flags [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] ins_vec, eq_vec, ins_first, eq_first;
   logic [IW-1:0] ins_pos, eq_pos, pos;
   logic hit, commit;
   logic [STAT_W-1:0] status;
   stfd_ctl_type ctl;

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         stfd_pkg::stfd_flags_type lf;
         logic signed [KEY_W-1:0] le, re;
         if (g == 0) begin : g_first
            assign lf = '0;
            assign le = key_ff;
         end else begin : g_mid
            assign lf = flags[g-1];
            assign le = entries[g-1];
         end
         if (g == TABLE_DEPTH - 1) begin : g_last
            assign re = entries[g];
         end else begin : g_inner
            assign re = entries[g+1];
         end
         stfd_cell #(.IDX(g), .CW(CW)) u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .key         (key_ff),
            .count       (count_ff),
            .left_entry  (le),
            .left_flags  (lf),
            .right_entry (re),
            .entry       (entries[g]),
            .flags       (flags[g])
         );
         assign ins_vec[g] = flags[g].ins;
         assign eq_vec[g]  = flags[g].eq;
      end
   endgenerate

   assign ins_first = ins_vec & ~(ins_vec << 1);
   assign eq_first  = eq_vec & ~(eq_vec << 1);
   assign hit = |eq_first;

   always_comb begin
      ins_pos = '0;
      eq_pos  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (ins_first[i]) ins_pos = ins_pos | IW'(i);
         if (eq_first[i])  eq_pos  = eq_pos | IW'(i);
      end
   end

   assign commit = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      ctl = '0;
      ctl.compare = (state_ff == S_CMP);
      status = ST_MISS;
      pos = '0;
      count_in = count_ff;
      unique case (action_ff)
         ACT_INSERT: begin
            if (count_ff == FULL_COUNT) begin
               status = ST_FULL;
            end else begin
               status = ST_DONE;
               pos = ins_pos;
               count_in = count_ff + CW'(1);
               ctl.shift_ins = commit;
            end
         end
         ACT_FIND: begin
            if (hit) begin
               status = ST_DONE;
               pos = eq_pos;
            end
         end
         ACT_DELETE: begin
            if (hit) begin
               status = ST_DONE;
               pos = eq_pos;
               count_in = count_ff - CW'(1);
               ctl.shift_del = commit;
            end
         end
         default: begin
            status = ST_MISS;
         end
      endcase
      if (!commit) count_in = count_ff;
   end

   always_comb begin
      state_in = state_ff;
      action_in = action_ff;
      key_in = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               action_in = req_tuser;
               key_in = req_tdata;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {1'b0, CNT_W'(count_in), POS_W'(pos), status};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff <= action_in;
      key_ff <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table depth");

   a_ins_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) && (action_ff == ACT_INSERT) && (count_ff != FULL_COUNT)
      |-> $onehot(ins_first))
      else $error("insert slot not unique");

   a_match_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> $onehot0(eq_first))
      else $error("matching entries not contiguous");

   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> (state_ff == S_CMP))
      else $error("accepted beat did not start compare");

   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("committed request left no response");

endmodule
`default_nettype wire
